// ===== rtl/tqle_pkg.sv =====
package tqle_pkg;

	// Table geometry. Both counts are powers of two, so out-of-range
	// indices wrap by keeping their low bits.
	localparam int NUM_ACTIONS = 16;
	localparam int STATE_COUNT = 256;
	localparam int AC_W        = $clog2(NUM_ACTIONS);
	localparam int ST_W        = $clog2(STATE_COUNT);
	localparam int ADDR_W      = ST_W + AC_W;
	localparam int TABLE_DEPTH = STATE_COUNT * NUM_ACTIONS;
	localparam int Q_W         = 32;

	// Depth of the command queue between front and back.
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);

	// Configuration register indices and reset values.
	localparam logic [1:0] CFG_LEARN_RATE = 2'd0;
	localparam logic [1:0] CFG_DISCOUNT   = 2'd1;
	localparam logic [1:0] CFG_EXPLORE    = 2'd2;
	localparam logic [15:0] LEARN_RATE_RESET = 16'd9830;
	localparam logic [15:0] DISCOUNT_RESET   = 16'd58982;
	localparam logic [15:0] EXPLORE_RESET    = 16'd6554;

	typedef struct packed {
		logic              mode;
		logic [7:0]        cur_state;
		logic [3:0]        upd_action;
		logic signed [31:0] reward;
		logic [7:0]        succ_state;
		logic [15:0]       explore_draw;
		logic [3:0]        random_action;
	} item_t;

	typedef struct packed {
		logic [3:0]         action;
		logic               explored;
		logic signed [31:0] q_value;
	} result_t;

	typedef enum logic [1:0] {
		KIND_EXPLOIT,
		KIND_EXPLORE,
		KIND_UPDATE
	} kind_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		kind_t              kind;
		logic [ST_W-1:0]    row;
		logic [AC_W-1:0]    col;
		logic [ST_W-1:0]    next_row;
		logic signed [31:0] reward;
	} cmd_t;

	typedef enum logic [3:0] {
		B_CLEAR,
		B_IDLE,
		B_SCAN,
		B_PICK,
		B_QREAD,
		B_QWAIT,
		B_MUL1,
		B_DIFF,
		B_MUL2,
		B_WRITE,
		B_DONE
	} bstate_t;

endpackage

// ===== rtl/tqle_ram.sv =====
module tqle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/tqle_front.sv =====
module tqle_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tqle_pkg::item_t     item,
	input  logic [15:0]         explore_threshold,
	input  logic                clearing,
	output logic                cmd_valid,
	output tqle_pkg::cmd_t      cmd,
	input  logic                cmd_pop
);

	tqle_pkg::cmd_t                       cmd_new;
	tqle_pkg::cmd_t                       cmdq_q [tqle_pkg::CMDQ_DEPTH];
	logic [tqle_pkg::CMDQ_PTR_W-1:0]      wr_ptr_q;
	logic [tqle_pkg::CMDQ_PTR_W-1:0]      rd_ptr_q;
	logic [tqle_pkg::CMDQ_PTR_W:0]        count_q;
	logic                                 accept;

	// Classify the incoming transaction and wrap its indices into the table.
	always_comb begin
		cmd_new.row      = tqle_pkg::ST_W'(item.cur_state);
		cmd_new.next_row = tqle_pkg::ST_W'(item.succ_state);
		cmd_new.reward   = item.reward;
		if (item.mode) begin
			cmd_new.kind = tqle_pkg::KIND_UPDATE;
			cmd_new.col  = tqle_pkg::AC_W'(item.upd_action);
		end else if (item.explore_draw < explore_threshold) begin
			cmd_new.kind = tqle_pkg::KIND_EXPLORE;
			cmd_new.col  = tqle_pkg::AC_W'(item.random_action);
		end else begin
			cmd_new.kind = tqle_pkg::KIND_EXPLOIT;
			cmd_new.col  = tqle_pkg::AC_W'(item.random_action);
		end
	end

	assign full      = clearing ||
		(count_q == (tqle_pkg::CMDQ_PTR_W + 1)'(tqle_pkg::CMDQ_DEPTH));
	assign accept    = push && !full;
	assign cmd_valid = (count_q != '0);
	assign cmd       = cmdq_q[rd_ptr_q];

	// Command queue storage.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmdq_q[wr_ptr_q] <= cmd_new;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!accept && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tqle_back.sv =====
module tqle_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         learn_rate,
	input  logic [15:0]         discount,
	input  logic                cmd_valid,
	input  tqle_pkg::cmd_t      cmd,
	output logic                cmd_pop,
	output logic                clearing,
	output logic                empty,
	input  logic                pop,
	output tqle_pkg::result_t   result
);

	tqle_pkg::bstate_t                state_q;
	tqle_pkg::bstate_t                state_nxt;
	tqle_pkg::cmd_t                   cur_q;
	logic [tqle_pkg::ADDR_W-1:0]      clr_q;
	logic [tqle_pkg::AC_W:0]          scan_cnt_q;
	logic                             scan_vld_s1;
	logic [tqle_pkg::AC_W-1:0]        scan_col_s1;
	logic signed [31:0]               best_q;
	logic [tqle_pkg::AC_W-1:0]        best_idx_q;
	logic signed [31:0]               qold_q;
	logic signed [32:0]               g_q;
	logic signed [34:0]               diff_q;
	logic signed [35:0]               delta_q;
	tqle_pkg::result_t                pend_q;
	tqle_pkg::result_t                res_q;
	logic                             res_valid_q;

	logic                             ram_we;
	logic [tqle_pkg::ADDR_W-1:0]      ram_waddr;
	logic [31:0]                      ram_wdata;
	logic [tqle_pkg::ADDR_W-1:0]      ram_raddr;
	logic [31:0]                      ram_rdata;
	logic signed [31:0]               rd_val;
	logic [tqle_pkg::ST_W-1:0]        scan_row;
	logic                             scan_issue;
	logic                             scan_last;
	logic                             res_free;

	logic signed [48:0]               prod1;
	logic signed [48:0]               prod1_rnd;
	logic signed [34:0]               diff;
	logic signed [51:0]               prod2;
	logic signed [51:0]               prod2_rnd;
	logic signed [36:0]               newq_wide;
	logic signed [31:0]               newq;

	tqle_ram #(
		.WIDTH (32),
		.DEPTH (tqle_pkg::TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rd_val     = $signed(ram_rdata);
	assign scan_row   = (cur_q.kind == tqle_pkg::KIND_UPDATE) ? cur_q.next_row : cur_q.row;
	assign scan_issue = (scan_cnt_q < (tqle_pkg::AC_W + 1)'(tqle_pkg::NUM_ACTIONS));
	assign scan_last  = scan_vld_s1 &&
		(scan_col_s1 == tqle_pkg::AC_W'(tqle_pkg::NUM_ACTIONS - 1));
	assign res_free   = !res_valid_q || pop;
	assign clearing   = (state_q == tqle_pkg::B_CLEAR);
	assign empty      = !res_valid_q;
	assign result     = res_q;

	// Update arithmetic: g = round(gamma * maxQ), delta = round(alpha * diff).
	assign prod1     = $signed({1'b0, discount}) * best_q;
	assign prod1_rnd = prod1 + 49'sd32768;
	assign diff      = {{3{cur_q.reward[31]}}, cur_q.reward} + {{2{g_q[32]}}, g_q}
		- {{3{qold_q[31]}}, qold_q};
	assign prod2     = $signed({1'b0, learn_rate}) * diff_q;
	assign prod2_rnd = prod2 + 52'sd32768;
	assign newq_wide = {{5{qold_q[31]}}, qold_q} + {delta_q[35], delta_q};

	// Saturate the new entry to 32 bits.
	always_comb begin
		if (newq_wide > 37'sd2147483647) begin
			newq = 32'sh7fffffff;
		end else if (newq_wide < -37'sd2147483648) begin
			newq = 32'sh80000000;
		end else begin
			newq = newq_wide[31:0];
		end
	end

	// Next-state logic of the sequencer.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tqle_pkg::B_CLEAR: begin
				if (clr_q == tqle_pkg::ADDR_W'(tqle_pkg::TABLE_DEPTH - 1)) begin
					state_nxt = tqle_pkg::B_IDLE;
				end
			end
			tqle_pkg::B_IDLE: begin
				if (cmd_valid) begin
					state_nxt = (cmd.kind == tqle_pkg::KIND_EXPLORE) ?
						tqle_pkg::B_QREAD : tqle_pkg::B_SCAN;
				end
			end
			tqle_pkg::B_SCAN: begin
				if (scan_last) begin
					state_nxt = tqle_pkg::B_PICK;
				end
			end
			tqle_pkg::B_PICK: begin
				state_nxt = (cur_q.kind == tqle_pkg::KIND_UPDATE) ?
					tqle_pkg::B_QREAD : tqle_pkg::B_DONE;
			end
			tqle_pkg::B_QREAD: state_nxt = tqle_pkg::B_QWAIT;
			tqle_pkg::B_QWAIT: begin
				state_nxt = (cur_q.kind == tqle_pkg::KIND_UPDATE) ?
					tqle_pkg::B_MUL1 : tqle_pkg::B_DONE;
			end
			tqle_pkg::B_MUL1:  state_nxt = tqle_pkg::B_DIFF;
			tqle_pkg::B_DIFF:  state_nxt = tqle_pkg::B_MUL2;
			tqle_pkg::B_MUL2:  state_nxt = tqle_pkg::B_WRITE;
			tqle_pkg::B_WRITE: state_nxt = tqle_pkg::B_DONE;
			tqle_pkg::B_DONE: begin
				if (res_free) begin
					state_nxt = tqle_pkg::B_IDLE;
				end
			end
			default: state_nxt = tqle_pkg::B_IDLE;
		endcase
	end

	// Table port and command queue controls for each state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		cmd_pop   = 1'b0;
		unique case (state_q)
			tqle_pkg::B_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
			end
			tqle_pkg::B_IDLE: begin
				cmd_pop = cmd_valid;
			end
			tqle_pkg::B_SCAN: begin
				ram_raddr = {scan_row, scan_cnt_q[tqle_pkg::AC_W-1:0]};
			end
			tqle_pkg::B_QREAD: begin
				ram_raddr = {cur_q.row, cur_q.col};
			end
			tqle_pkg::B_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = {cur_q.row, cur_q.col};
				ram_wdata = newq;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer state and clearing sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tqle_pkg::B_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == tqle_pkg::B_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Row scan control: one read issued per cycle, its data returned in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			scan_vld_s1 <= 1'b0;
		end else if (state_q == tqle_pkg::B_SCAN) begin
			scan_vld_s1 <= scan_issue;
			if (scan_issue) begin
				scan_cnt_q <= scan_cnt_q + 1'b1;
			end
		end else begin
			scan_cnt_q  <= '0;
			scan_vld_s1 <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == tqle_pkg::B_IDLE && cmd_valid) begin
			cur_q <= cmd;
		end
		if (state_q == tqle_pkg::B_SCAN) begin
			scan_col_s1 <= scan_cnt_q[tqle_pkg::AC_W-1:0];
			// The first maximum wins, so only a strictly larger value replaces it.
			if (scan_vld_s1 && (scan_col_s1 == '0 || rd_val > best_q)) begin
				best_q     <= rd_val;
				best_idx_q <= scan_col_s1;
			end
		end
		if (state_q == tqle_pkg::B_PICK) begin
			pend_q.action   <= 4'(best_idx_q);
			pend_q.explored <= 1'b0;
			pend_q.q_value  <= best_q;
		end
		if (state_q == tqle_pkg::B_QWAIT) begin
			qold_q          <= rd_val;
			pend_q.action   <= 4'(cur_q.col);
			pend_q.explored <= 1'b1;
			pend_q.q_value  <= rd_val;
		end
		if (state_q == tqle_pkg::B_MUL1) begin
			g_q <= prod1_rnd[48:16];
		end
		if (state_q == tqle_pkg::B_DIFF) begin
			diff_q <= diff;
		end
		if (state_q == tqle_pkg::B_MUL2) begin
			delta_q <= prod2_rnd[51:16];
		end
		if (state_q == tqle_pkg::B_WRITE) begin
			pend_q.action   <= 4'(cur_q.col);
			pend_q.explored <= 1'b0;
			pend_q.q_value  <= newq;
		end
		if (state_q == tqle_pkg::B_DONE && res_free) begin
			res_q <= pend_q;
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == tqle_pkg::B_DONE && res_free) begin
			res_valid_q <= 1'b1;
		end else if (pop) begin
			res_valid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/tabular_q_learning_engine_core.sv =====
// Tabular Q-learning engine with epsilon-greedy action choice. Transactions enter through
// a push/full queue interface and results leave through an empty/pop queue interface,
// one result per transaction, in order. After reset the engine sweeps the 4096-entry
// Q table to zero, one entry per cycle, holding full high throughout the sweep;
// configuration writes are taken at any time (cfg_ready is always high) but should only
// be issued while the engine is idle. Work is sequenced through the single read port
// of the table: an exploring choose reads its chosen entry, an exploiting choose scans the
// sixteen-entry row, and an update scans the successor row, reads the old entry and then
// passes through the two multiply stages and the write-back. A two-entry command queue
// lets new transactions be accepted while one is in flight, and a result register holds
// a finished result until it is popped.
module tabular_q_learning_engine_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  tqle_pkg::item_t     item,
	output logic                empty,
	input  logic                pop,
	output tqle_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	logic [15:0]      learn_rate_q;
	logic [15:0]      discount_q;
	logic [15:0]      explore_q;
	logic             cmd_valid;
	logic             cmd_pop;
	logic             clearing;
	tqle_pkg::cmd_t   cmd;

	assign cfg_ready = 1'b1;

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learn_rate_q <= tqle_pkg::LEARN_RATE_RESET;
			discount_q   <= tqle_pkg::DISCOUNT_RESET;
			explore_q    <= tqle_pkg::EXPLORE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tqle_pkg::CFG_LEARN_RATE: learn_rate_q <= cfg_data;
				tqle_pkg::CFG_DISCOUNT:   discount_q   <= cfg_data;
				tqle_pkg::CFG_EXPLORE:    explore_q    <= cfg_data;
				default:                  learn_rate_q <= learn_rate_q;
			endcase
		end
	end

	// Front end: classification and command queue.
	tqle_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.push              (push),
		.full              (full),
		.item              (item),
		.explore_threshold (explore_q),
		.clearing          (clearing),
		.cmd_valid         (cmd_valid),
		.cmd               (cmd),
		.cmd_pop           (cmd_pop)
	);

	// Back end: table scan, update arithmetic and result register.
	tqle_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.learn_rate (learn_rate_q),
		.discount   (discount_q),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.clearing   (clearing),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

// ===== test/tb_tabular_q_learning_engine_core.sv =====
`timescale 1ns / 100ps

module tb_tabular_q_learning_engine_core;

	// Item modes and the register index that decodes to nothing.
	localparam logic       MODE_CHOOSE = 1'b0;
	localparam logic       MODE_UPDATE = 1'b1;
	localparam logic [1:0] CFG_UNUSED  = 2'd3;

	localparam longint Q_MAX         = 64'sd2147483647;
	localparam longint Q_MIN         = -64'sd2147483648;
	localparam int     ITEMS_PER_SEG = 335;

	// One row of the directed table: either a register set or an item.
	typedef struct {
		bit                is_cfg;
		logic [15:0]       lr;
		logic [15:0]       dc;
		logic [15:0]       ex;
		bit                dummy;
		tqle_pkg::item_t   it;
		bit                typed;
		tqle_pkg::result_t want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              push = 1'b0;
	logic              full;
	tqle_pkg::item_t   item = '0;
	logic              empty;
	logic              pop = 1'b0;
	tqle_pkg::result_t result;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = '0;
	logic [15:0]       cfg_data = '0;

	// Shadow copy of the Q table and of the three registers.
	logic signed [31:0] q_tab [tqle_pkg::TABLE_DEPTH];
	logic [15:0]        alpha = tqle_pkg::LEARN_RATE_RESET;
	logic [15:0]        gamma = tqle_pkg::DISCOUNT_RESET;
	logic [15:0]        eps   = tqle_pkg::EXPLORE_RESET;

	tqle_pkg::result_t pending_q[$];
	int                fail_count = 0;
	int                send_idle_pct = 34;
	int                recv_idle_pct = 80;

	tabular_q_learning_engine_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// First column holding the maximum of a row.
	function automatic logic [tqle_pkg::AC_W-1:0] best_col(
			input logic [tqle_pkg::ST_W-1:0] row);
		logic [tqle_pkg::AC_W-1:0] best;
		logic signed [31:0]        top;
		best = '0;
		top  = q_tab[{row, best}];
		for (int c = 1; c < tqle_pkg::NUM_ACTIONS; c++) begin
			if (q_tab[{row, tqle_pkg::AC_W'(c)}] > top) begin
				best = tqle_pkg::AC_W'(c);
				top  = q_tab[{row, best}];
			end
		end
		return best;
	endfunction

	// Works out the result of one item and applies any table write.
	function automatic tqle_pkg::result_t predict_q(input tqle_pkg::item_t it);
		tqle_pkg::result_t           r;
		logic [tqle_pkg::AC_W-1:0]   col;
		logic [tqle_pkg::ADDR_W-1:0] addr;
		longint                      maxq, cur, g, diff, delta, nv;
		r = '0;
		if (it.mode == MODE_CHOOSE) begin
			if (it.explore_draw < eps) begin
				col        = it.random_action;
				r.explored = 1'b1;
			end else begin
				col = best_col(it.cur_state);
			end
			r.action  = col;
			r.q_value = q_tab[{it.cur_state, col}];
		end else begin
			col   = it.upd_action;
			addr  = {it.cur_state, col};
			maxq  = q_tab[{it.succ_state, best_col(it.succ_state)}];
			cur   = q_tab[addr];
			// Both products round half up; the arithmetic shift floors.
			g     = (longint'(gamma) * maxq + 32768) >>> 16;
			diff  = longint'($signed(it.reward)) + g - cur;
			delta = (longint'(alpha) * diff + 32768) >>> 16;
			nv    = cur + delta;
			if (nv > Q_MAX)
				nv = Q_MAX;
			if (nv < Q_MIN)
				nv = Q_MIN;
			q_tab[addr] = nv[31:0];
			r.action    = col;
			r.q_value   = nv[31:0];
		end
		return r;
	endfunction

	function automatic dir_row_t choose_row(input logic [7:0] st, input logic [15:0] draw,
			input logic [3:0] ract, input bit typed, input logic [3:0] act,
			input logic expl, input logic [31:0] q);
		dir_row_t row;
		row = '{default: '0};
		row.it.mode         = MODE_CHOOSE;
		row.it.cur_state    = st;
		row.it.explore_draw = draw;
		row.it.random_action = ract;
		row.typed           = typed;
		row.want            = '{action: act, explored: expl, q_value: q};
		return row;
	endfunction

	function automatic dir_row_t update_row(input logic [7:0] st, input logic [3:0] col,
			input logic [31:0] rew, input logic [7:0] nxt, input bit typed,
			input logic [31:0] q);
		dir_row_t row;
		row = '{default: '0};
		row.it.mode         = MODE_UPDATE;
		row.it.cur_state    = st;
		row.it.upd_action   = col;
		row.it.reward       = rew;
		row.it.succ_state   = nxt;
		row.typed           = typed;
		row.want            = '{action: col, explored: 1'b0, q_value: q};
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic [15:0] lr, input logic [15:0] dc,
			input logic [15:0] ex, input bit dummy);
		dir_row_t row;
		row = '{default: '0};
		row.is_cfg = 1'b1;
		row.lr     = lr;
		row.dc     = dc;
		row.ex     = ex;
		row.dummy  = dummy;
		return row;
	endfunction

	// Random item; most rows come from a small hot set so values build up.
	// A bias of 1 pushes rewards negative, a bias of 2 positive.
	function automatic tqle_pkg::item_t gen_item(input int hot, input int bias);
		tqle_pkg::item_t it;
		int              r;
		logic [31:0]     rew;
		it.mode          = 1'($urandom_range(1));
		it.cur_state     = ($urandom_range(99) < 85) ? 8'($urandom_range(hot - 1)) :
			8'($urandom_range(255));
		it.succ_state    = ($urandom_range(99) < 85) ? 8'($urandom_range(hot - 1)) :
			8'($urandom_range(255));
		it.upd_action    = 4'($urandom_range(15));
		it.random_action = 4'($urandom_range(15));
		r = $urandom_range(99);
		if (r < 15) begin
			case ($urandom_range(3))
				0: rew = 32'h7FFF_FFFF;
				1: rew = 32'h8000_0000;
				2: rew = 32'h0000_0000;
				default: rew = 32'hFFFF_FFFF;
			endcase
		end else if (r < 45) begin
			rew = $urandom_range(32'h3_FFFF) - 32'h1_FFFF;
		end else begin
			rew = $urandom;
		end
		if (bias == 1 && $urandom_range(99) < 80)
			rew[31] = 1'b1;
		if (bias == 2 && $urandom_range(99) < 80)
			rew[31] = 1'b0;
		it.reward = rew;
		// Draws lean on the threshold boundary and the extremes.
		r = $urandom_range(99);
		if (r < 50)
			it.explore_draw = 16'($urandom_range(65535));
		else if (r < 70)
			it.explore_draw = eps;
		else if (r < 80)
			it.explore_draw = (eps == 0) ? 16'd0 : eps - 16'd1;
		else if (r < 90)
			it.explore_draw = 16'd0;
		else
			it.explore_draw = 16'hFFFF;
		return it;
	endfunction

	// Presents one item after a random gap and holds it until accepted.
	task automatic send_item(input tqle_pkg::item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Stops sending and waits until every expected result has been popped.
	task automatic drain();
		push <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
	endtask

	// Writes the three registers, optionally followed by the unused index.
	task automatic program_regs(input logic [15:0] lr, input logic [15:0] dc,
			input logic [15:0] ex, input bit dummy);
		logic [1:0]  idx [4];
		logic [15:0] val [4];
		int          n;
		idx = '{tqle_pkg::CFG_LEARN_RATE, tqle_pkg::CFG_DISCOUNT, tqle_pkg::CFG_EXPLORE,
			CFG_UNUSED};
		val = '{lr, dc, ex, 16'h0000};
		n   = dummy ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[i])
				tqle_pkg::CFG_LEARN_RATE: alpha = val[i];
				tqle_pkg::CFG_DISCOUNT:   gamma = val[i];
				tqle_pkg::CFG_EXPLORE:    eps   = val[i];
				default: ;
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic note_mismatch(input string field, input longint want, input longint got);
		fail_count++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
	endtask

	// Compares one popped result with the oldest expectation.
	task automatic check_result(input tqle_pkg::result_t got);
		tqle_pkg::result_t want;
		if (pending_q.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected result, expected none, actual action %0d q_value %0d",
				$time, got.action, $signed(got.q_value));
		end else begin
			want = pending_q.pop_front();
			if (got.action !== want.action)
				note_mismatch("action", want.action, got.action);
			if (got.explored !== want.explored)
				note_mismatch("explored", want.explored, got.explored);
			if (got.q_value !== want.q_value)
				note_mismatch("q_value", $signed(want.q_value), $signed(got.q_value));
		end
	endtask

	// Result side: check each popped transaction, then decide the next pop.
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			check_result(result);
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		dir_row_t          rows[$];
		tqle_pkg::item_t   it;
		tqle_pkg::result_t got;
		logic [15:0]       lr, dc, ex;
		bit                dummy;
		int                hot, bias;

		for (int i = 0; i < tqle_pkg::TABLE_DEPTH; i++)
			q_tab[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table: cleared table and reset registers first.
		rows.push_back(choose_row(8'd0, 16'hFFFF, 4'd0, 1, 4'd0, 1'b0, 32'd0));
		rows.push_back(choose_row(8'd255, 16'h0000, 4'd15, 1, 4'd15, 1'b1, 32'd0));
		rows.push_back(choose_row(8'd17, tqle_pkg::EXPLORE_RESET - 16'd1, 4'd5, 1, 4'd5,
			1'b1, 32'd0));
		rows.push_back(choose_row(8'd17, tqle_pkg::EXPLORE_RESET, 4'd5, 1, 4'd0, 1'b0,
			32'd0));
		rows.push_back(update_row(8'd2, 4'd0, 32'd0, 8'd2, 1, 32'd0));
		// Two columns get the same value, so the lower one must win the tie.
		rows.push_back(update_row(8'd0, 4'd3, 32'h7FFF_FFFF, 8'd1, 0, '0));
		rows.push_back(update_row(8'd0, 4'd5, 32'h7FFF_FFFF, 8'd1, 0, '0));
		rows.push_back(choose_row(8'd0, 16'hFFFF, 4'd0, 0, '0, '0, '0));
		rows.push_back(update_row(8'd255, 4'd15, 32'h8000_0000, 8'd0, 0, '0));
		rows.push_back(choose_row(8'd255, 16'hFFFF, 4'd0, 0, '0, '0, '0));
		rows.push_back(update_row(8'd1, 4'd7, 32'd1, 8'd3, 0, '0));
		// Full learning rate and discount drive the entry into saturation;
		// a zero threshold must never explore.
		rows.push_back(cfg_row(16'hFFFF, 16'hFFFF, 16'h0000, 0));
		rows.push_back(update_row(8'd4, 4'd0, 32'h7FFF_FFFF, 8'd4, 0, '0));
		rows.push_back(update_row(8'd4, 4'd0, 32'h7FFF_FFFF, 8'd4, 0, '0));
		rows.push_back(update_row(8'd4, 4'd0, 32'h7FFF_FFFF, 8'd4, 0, '0));
		rows.push_back(choose_row(8'd4, 16'h0000, 4'd9, 0, '0, '0, '0));
		// Maximum threshold, then a write to the unused index that must not land.
		rows.push_back(cfg_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1));
		rows.push_back(choose_row(8'd6, 16'hFFFF, 4'd2, 1, 4'd0, 1'b0, 32'd0));
		rows.push_back(choose_row(8'd6, 16'hFFFE, 4'd2, 1, 4'd2, 1'b1, 32'd0));
		// Zero learning rate leaves entries unchanged.
		rows.push_back(cfg_row(16'h0000, 16'h0000, tqle_pkg::EXPLORE_RESET, 0));
		rows.push_back(update_row(8'd4, 4'd0, 32'h1234_5678, 8'd4, 0, '0));
		rows.push_back(update_row(8'd0, 4'd3, 32'hFFFF_FFFF, 8'd0, 0, '0));
		rows.push_back(choose_row(8'd0, 16'hFFFF, 4'd0, 0, '0, '0, '0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				drain();
				program_regs(rows[i].lr, rows[i].dc, rows[i].ex, rows[i].dummy);
			end else begin
				send_item(rows[i].it);
				got = predict_q(rows[i].it);
				pending_q.push_back(rows[i].typed ? rows[i].want : got);
			end
		end

		// Random segments, each under its own register setting; idling changes every two segments.
		for (int seg = 0; seg < 6; seg++) begin
			dummy = 1'b0;
			hot   = 8;
			bias  = 0;
			case (seg)
				0: begin
					lr = tqle_pkg::LEARN_RATE_RESET; dc = tqle_pkg::DISCOUNT_RESET;
					ex = tqle_pkg::EXPLORE_RESET;
				end
				1: begin
					lr = 16'hFFFF; dc = 16'hFFFF; ex = 16'h0000; hot = 2; bias = 1;
				end
				2: begin
					lr = 16'h0000; dc = 16'h0000; ex = 16'hFFFF;
				end
				3: begin
					lr = 16'($urandom_range(65535)); dc = 16'($urandom_range(65535));
					ex = 16'($urandom_range(65535)); dummy = 1'b1; hot = 16;
				end
				4: begin
					lr = 16'h8000; dc = 16'hFFFF; ex = 16'h8000; hot = 2; bias = 2;
				end
				default: begin
					lr = 16'($urandom_range(65535)); dc = 16'($urandom_range(65535));
					ex = 16'($urandom_range(65535));
				end
			endcase
			send_idle_pct = (seg < 2) ? 34 : (seg < 4) ? 80 : 0;
			recv_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 34 : 0;
			drain();
			program_regs(lr, dc, ex, dummy);
			repeat (ITEMS_PER_SEG) begin
				it = gen_item(hot, bias);
				send_item(it);
				pending_q.push_back(predict_q(it));
			end
		end

		// Let the last results out, then wait so that anything spurious can show up.
		drain();
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tqle_pkg.sv
rtl/tqle_ram.sv
rtl/tqle_front.sv
rtl/tqle_back.sv
rtl/tabular_q_learning_engine_core.sv
test/tb_tabular_q_learning_engine_core.sv
